@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the role queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, ignoring cycles spent in reset.
`define LORQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define LORQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/lorq_pkg.sv @@
// Package with the types, constants and codes of the role queue.
`timescale 1ns / 1ps

package lorq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 16;
    localparam int SOURCE_BITS = 8;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int ACT_BITS    = 2;

    localparam int IN_DATA_BITS   = TIME_BITS + SOURCE_BITS;
    localparam int IN_TDATA_BITS  = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int IN_TUSER_BITS  = ACT_BITS + 1;
    localparam int OUT_DATA_BITS  = TIME_BITS + CNT_BITS + 1 + SOURCE_BITS + 1;
    localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;

    localparam logic [ACT_BITS-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_QUERY  = 2'd2;

    localparam logic ROLE_VICTIM = 1'b0;
    localparam logic ROLE_KILLER = 1'b1;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef struct packed {
        logic [TIME_BITS-1:0]   time_stamp;
        logic [SOURCE_BITS-1:0] source;
        logic                   role;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } t_cell_op;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        t_cell_op op;
        logic     role;
        t_entry   entry;
    } t_cell_ctrl;

    // Handed from each cell to its right neighbor.
    typedef struct packed {
        logic                   gt;
        logic                   hit;
        logic                   kill_seen;
        logic [SOURCE_BITS-1:0] kill_src;
    } t_link;

endpackage

@@ hdl/lorq_cell.sv @@
// One cell of the sorted chain: holds one queue entry.
`timescale 1ns / 1ps

module lorq_cell (
    input  logic                i_clk,
    input  lorq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occ,
    input  lorq_pkg::t_link     i_link,
    input  lorq_pkg::t_entry    i_left_entry,
    input  lorq_pkg::t_entry    i_right_entry,
    output lorq_pkg::t_entry    o_entry,
    output lorq_pkg::t_link     o_link
);

    lorq_pkg::t_entry r_entry;
    lorq_pkg::t_entry n_entry;
    logic             w_after;

    // Held entry sorts strictly after the new one.
    assign w_after = (r_entry.time_stamp > i_ctrl.entry.time_stamp) ||
                     ((r_entry.time_stamp == i_ctrl.entry.time_stamp) &&
                      (r_entry.source > i_ctrl.entry.source));

    always_comb begin
        o_link.gt        = !i_occ || w_after;
        o_link.hit       = i_link.hit || (i_occ && (r_entry.role == i_ctrl.role));
        o_link.kill_seen = i_link.kill_seen || (i_occ && (r_entry.role == lorq_pkg::ROLE_KILLER));
        o_link.kill_src  = i_link.kill_seen ? i_link.kill_src : r_entry.source;
    end

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            lorq_pkg::CELL_INSERT: begin
                if (i_link.gt) begin
                    n_entry = i_left_entry;
                end else if (o_link.gt) begin
                    n_entry = i_ctrl.entry;
                end
            end
            lorq_pkg::CELL_REMOVE: begin
                // close the gap left by the first matching entry
                if (o_link.hit) begin
                    n_entry = i_right_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

@@ hdl/lorq_lamport_clock.sv @@
// Saturating Lamport clock register.
`timescale 1ns / 1ps

module lorq_lamport_clock (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_update,
    input  logic [lorq_pkg::TIME_BITS-1:0] i_time,
    output logic [lorq_pkg::TIME_BITS-1:0] o_clock
);

    logic [lorq_pkg::TIME_BITS-1:0] r_clock;
    logic [lorq_pkg::TIME_BITS-1:0] n_clock;
    logic [lorq_pkg::TIME_BITS-1:0] w_max;

    always_comb begin
        w_max = (i_time > r_clock) ? i_time : r_clock;
        n_clock = r_clock;
        if (i_update) begin
            n_clock = (w_max == lorq_pkg::TIME_MAX) ? w_max
                                                    : w_max + lorq_pkg::TIME_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
        end else begin
            r_clock <= n_clock;
        end
    end

    assign o_clock = r_clock;

endmodule

@@ hdl/lamport_ordered_role_queue.sv @@
// Top level of the Lamport-ordered role queue: controller and cell chain.
// Usage
//   Input stream (s_axis): one item per received message. tdata carries the
//   timestamp and the sending source, tuser the action and the sender role.
//   Actions: insert the entry, remove the earliest victim and then the
//   earliest killer, or query only (code 3 also queries).
//   Output stream (m_axis): exactly one result item per input item, in order,
//   reporting the clock, the entry count, the earliest queued killer and
//   whether an insert was dropped on a full queue.
// Sequence
//   Insert and query go from the accepting edge to the report state, which loads
//   the output register; remove passes the killer state first, one removal per
//   step (victim, then killer), as the cell chain shifts once per cycle. The input
//   is ready again after that load, so no item enters before the last is reported.
// Reset and stall
//   Reset clears the clock, the entry count and the control state; entry
//   payloads are left as they are, since only counted cells are ever read.
//   A result waits in the output register while the receiver stalls; the
//   block still takes the next item, and holds in its report cycle only when
//   the register is still full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lamport_ordered_role_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata, low bit up: msg_time[15:0], msg_source[23:16]
    input  logic [lorq_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    // tuser, low bit up: action[1:0], sender_role[2]
    input  logic [lorq_pkg::IN_TUSER_BITS-1:0]  i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata, low bit up: clock_value[15:0], entry_count[20:16],
    // killer_found[21], first_killer_source[29:22], insert_dropped[30], zero pad
    output logic [lorq_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata
);

    localparam int DEPTH = lorq_pkg::QUEUE_DEPTH;
    localparam int CNTW  = lorq_pkg::CNT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_KILL = 3'b010,
        ST_RPT  = 3'b100
    } t_state;

    t_state                                r_state;
    t_state                                n_state;
    logic [CNTW-1:0]                       r_count;
    logic [CNTW-1:0]                       n_count;
    logic                                  r_dropped;
    logic                                  r_out_valid;
    logic [lorq_pkg::OUT_TDATA_BITS-1:0]   r_out_data;

    logic                                  w_accept;
    logic                                  w_full;
    logic                                  w_load;
    logic [lorq_pkg::ACT_BITS-1:0]         w_action;
    lorq_pkg::t_entry                      w_in_entry;
    lorq_pkg::t_cell_ctrl                  w_ctrl;
    logic [lorq_pkg::TIME_BITS-1:0]        w_clock;
    logic [lorq_pkg::SOURCE_BITS-1:0]      w_kill_src;

    logic             w_occ   [DEPTH];
    lorq_pkg::t_entry w_entry [DEPTH];
    lorq_pkg::t_link  w_link  [DEPTH+1];

    // Unpack the input item.
    assign w_action              = i_s_axis_tuser[lorq_pkg::ACT_BITS-1:0];
    assign w_in_entry.role       = i_s_axis_tuser[lorq_pkg::ACT_BITS];
    assign w_in_entry.time_stamp = i_s_axis_tdata[lorq_pkg::TIME_BITS-1:0];
    assign w_in_entry.source     = i_s_axis_tdata[lorq_pkg::IN_DATA_BITS-1:lorq_pkg::TIME_BITS];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full          = (r_count == CNTW'(DEPTH));
    assign w_load          = (r_state == ST_RPT) && (!r_out_valid || i_m_axis_tready);

    lorq_lamport_clock u_clock (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_accept),
        .i_time   (w_in_entry.time_stamp),
        .o_clock  (w_clock)
    );

    // Chain of cells, cell 0 holds the earliest entry.
    assign w_link[0] = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        lorq_pkg::t_entry w_left;
        lorq_pkg::t_entry w_right;

        assign w_occ[k] = (r_count > CNTW'(k));

        if (k == 0) begin : g_first
            assign w_left = w_ctrl.entry;
        end else begin : g_inner
            assign w_left = w_entry[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign w_right = w_entry[k];
        end else begin : g_body
            assign w_right = w_entry[k+1];
        end

        lorq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_occ         (w_occ[k]),
            .i_link        (w_link[k]),
            .i_left_entry  (w_left),
            .i_right_entry (w_right),
            .o_entry       (w_entry[k]),
            .o_link        (w_link[k+1])
        );
    end

    // Drive the chain and advance the controller.
    always_comb begin
        w_ctrl.op    = lorq_pkg::CELL_HOLD;
        w_ctrl.role  = lorq_pkg::ROLE_VICTIM;
        w_ctrl.entry = w_in_entry;
        n_state      = r_state;
        n_count      = r_count;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_action == lorq_pkg::ACT_REMOVE) ? ST_KILL : ST_RPT;
                    if (w_action == lorq_pkg::ACT_INSERT && !w_full) begin
                        w_ctrl.op = lorq_pkg::CELL_INSERT;
                        n_count   = r_count + CNTW'(1);
                    end else if (w_action == lorq_pkg::ACT_REMOVE) begin
                        w_ctrl.op = lorq_pkg::CELL_REMOVE;
                        if (w_link[DEPTH].hit) begin
                            n_count = r_count - CNTW'(1);
                        end
                    end
                end
            end
            ST_KILL: begin
                w_ctrl.op   = lorq_pkg::CELL_REMOVE;
                w_ctrl.role = lorq_pkg::ROLE_KILLER;
                n_state     = ST_RPT;
                if (w_link[DEPTH].hit) begin
                    n_count = r_count - CNTW'(1);
                end
            end
            ST_RPT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_kill_src = w_link[DEPTH].kill_seen ? w_link[DEPTH].kill_src : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: drop flag and result word.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dropped <= (w_action == lorq_pkg::ACT_INSERT) && w_full;
        end
        if (w_load) begin
            r_out_data <= lorq_pkg::OUT_TDATA_BITS'({r_dropped, w_kill_src,
                                                    w_link[DEPTH].kill_seen,
                                                    r_count, w_clock});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `LORQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNTW'(DEPTH),
                 "entry count above depth")
    `LORQ_ASSERT(a_remove_kill, i_clk, i_rst_n,
                 (w_accept && (w_action == lorq_pkg::ACT_REMOVE)) |=> (r_state == ST_KILL),
                 "remove did not enter killer step")
    `LORQ_ASSERT(a_clock_mono, i_clk, i_rst_n,
                 w_accept |=> (w_clock >= $past(w_clock)), "Lamport clock went backward")

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the Lamport-ordered role queue.
`timescale 1ns / 1ps

module tb_top;

    localparam int ACT_BITS       = lorq_pkg::ACT_BITS;
    localparam int TIME_BITS      = lorq_pkg::TIME_BITS;
    localparam int SOURCE_BITS    = lorq_pkg::SOURCE_BITS;
    localparam int CNT_BITS       = lorq_pkg::CNT_BITS;
    localparam int QUEUE_DEPTH    = lorq_pkg::QUEUE_DEPTH;
    localparam int IN_TDATA_BITS  = lorq_pkg::IN_TDATA_BITS;
    localparam int IN_TUSER_BITS  = lorq_pkg::IN_TUSER_BITS;
    localparam int OUT_DATA_BITS  = lorq_pkg::OUT_DATA_BITS;
    localparam int OUT_TDATA_BITS = lorq_pkg::OUT_TDATA_BITS;

    localparam logic [ACT_BITS-1:0]  ACT_INSERT  = lorq_pkg::ACT_INSERT;
    localparam logic [ACT_BITS-1:0]  ACT_REMOVE  = lorq_pkg::ACT_REMOVE;
    localparam logic [ACT_BITS-1:0]  ACT_QUERY   = lorq_pkg::ACT_QUERY;
    localparam logic                 ROLE_VICTIM = lorq_pkg::ROLE_VICTIM;
    localparam logic                 ROLE_KILLER = lorq_pkg::ROLE_KILLER;
    localparam logic [TIME_BITS-1:0] TIME_MAX    = lorq_pkg::TIME_MAX;

    // The block treats this code as a plain query.
    localparam logic [ACT_BITS-1:0] ACT_SPARE = 2'd3;

    localparam int LIMIT_NS        = 2_000_000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int SETTLE_CYCLES   = 8;

    // One input item, as packed onto tdata and tuser.
    typedef struct packed {
        logic [ACT_BITS-1:0]    action;
        logic [TIME_BITS-1:0]   stamp;
        logic [SOURCE_BITS-1:0] source;
        logic                   role;
    } t_message;

    // One result item; the field order matches the output tdata from the top bit down.
    typedef struct packed {
        logic                   dropped;
        logic [SOURCE_BITS-1:0] killer_src;
        logic                   killer_seen;
        logic [CNT_BITS-1:0]    depth;
        logic [TIME_BITS-1:0]   lamport;
    } t_report;

    // A directed row: the message and, where pinned, the result typed in by hand.
    typedef struct packed {
        t_message msg;
        logic     pinned;
        t_report  want;
    } t_plan_row;

    localparam t_report NO_PIN = '0;

    // Rows from HOLD_BACK_FROM on pin the clock at its maximum, and the clock never
    // comes back down, so walk them only after the random part.
    localparam int PLAN_ROWS      = 31;
    localparam int HOLD_BACK_FROM = 28;

    // Pinned results read: '{dropped, killer_src, killer_seen, depth, clock}.
    localparam t_plan_row PLAN [0:PLAN_ROWS-1] = '{
        // Fresh after reset: query, remove on an empty queue, the spare code.
        '{'{ACT_QUERY,  16'h0000, 8'h00, ROLE_VICTIM}, 1'b1, '{1'b0, 8'd0, 1'b0, 5'd0, 16'd1}},
        '{'{ACT_REMOVE, 16'h0000, 8'h00, ROLE_VICTIM}, 1'b1, '{1'b0, 8'd0, 1'b0, 5'd0, 16'd2}},
        '{'{ACT_SPARE,  16'h0005, 8'hAA, ROLE_KILLER}, 1'b1, '{1'b0, 8'd0, 1'b0, 5'd0, 16'd6}},
        // Lone victim, then a remove that finds no killer.
        '{'{ACT_INSERT, 16'h0064, 8'h00, ROLE_VICTIM}, 1'b1, '{1'b0, 8'd0, 1'b0, 5'd1, 16'd101}},
        '{'{ACT_REMOVE, 16'h0000, 8'h00, ROLE_VICTIM}, 1'b1, '{1'b0, 8'd0, 1'b0, 5'd0, 16'd102}},
        // Same timestamp: lower source goes ahead, an equal key goes behind.
        '{'{ACT_INSERT, 16'h0064, 8'hFF, ROLE_KILLER}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h0064, 8'h00, ROLE_VICTIM}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h0064, 8'hFF, ROLE_KILLER}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h0032, 8'h07, ROLE_KILLER}, 1'b0, NO_PIN},
        '{'{ACT_REMOVE, 16'h0000, 8'h00, ROLE_VICTIM}, 1'b0, NO_PIN},
        // No victim left: only the killer part removes.
        '{'{ACT_REMOVE, 16'h0000, 8'h00, ROLE_VICTIM}, 1'b0, NO_PIN},
        // Top time bit alone, then all the others below the clock.
        '{'{ACT_INSERT, 16'h8000, 8'h00, ROLE_VICTIM}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h7FFF, 8'h01, ROLE_VICTIM}, 1'b0, NO_PIN},
        // Fill up to the full depth.
        '{'{ACT_INSERT, 16'h0000, 8'hFF, ROLE_KILLER}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h0000, 8'h00, ROLE_VICTIM}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h00FF, 8'h80, ROLE_KILLER}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h1234, 8'h55, ROLE_VICTIM}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h7FFF, 8'h01, ROLE_KILLER}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h0064, 8'hFF, ROLE_VICTIM}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h4000, 8'h10, ROLE_KILLER}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h2000, 8'h20, ROLE_VICTIM}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h0001, 8'hFE, ROLE_KILLER}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h7FFE, 8'h02, ROLE_VICTIM}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h0A0A, 8'h33, ROLE_KILLER}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h5555, 8'hAA, ROLE_VICTIM}, 1'b0, NO_PIN},
        '{'{ACT_INSERT, 16'h2AAA, 8'h54, ROLE_KILLER}, 1'b0, NO_PIN},
        // Queue full: drop the entry, still advance the clock.
        '{'{ACT_INSERT, 16'h0100, 8'h03, ROLE_KILLER}, 1'b0, NO_PIN},
        '{'{ACT_QUERY,  16'h8000, 8'h00, ROLE_VICTIM}, 1'b0, NO_PIN},
        // Held back: saturate the clock, then hold it there.
        '{'{ACT_INSERT, 16'hFFFF, 8'hFF, ROLE_KILLER}, 1'b0, NO_PIN},
        '{'{ACT_QUERY,  16'h0000, 8'h00, ROLE_VICTIM}, 1'b0, NO_PIN},
        '{'{ACT_REMOVE, 16'hFFFF, 8'hFF, ROLE_KILLER}, 1'b0, NO_PIN}
    };

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata  = '0;
    logic [IN_TUSER_BITS-1:0]  s_tuser  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    // Queue shadow: held entries in key order, their count and the Lamport clock.
    lorq_pkg::t_entry     held [QUEUE_DEPTH];
    int                   held_count  = 0;
    logic [TIME_BITS-1:0] lamport_now = '0;

    t_report pending_reports [$];

    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    int   mismatch_count     = 0;
    int   results_seen       = 0;
    int   n_inserts          = 0;
    int   n_dropped          = 0;
    int   n_removes          = 0;
    int   n_queries          = 0;
    int   peak_depth         = 0;
    logic filling            = 1'b1;
    logic [TIME_BITS-1:0] last_stamp = '0;

    lamport_ordered_role_queue dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Delete the earliest held entry of the given role, if there is one.
    function automatic void drop_first_of_role(input logic role);
        int hit;
        hit = -1;
        for (int k = 0; k < held_count; k++) begin
            if (hit < 0 && held[k].role == role) begin
                hit = k;
            end
        end
        if (hit >= 0) begin
            for (int k = hit; k + 1 < held_count; k++) begin
                held[k] = held[k + 1];
            end
            held_count--;
        end
    endfunction

    // Advance the shadow by one message and return the result it should produce.
    function automatic t_report apply_message(input t_message m);
        t_report          r;
        lorq_pkg::t_entry fresh;
        int               pos;
        r = '0;
        if (m.stamp > lamport_now) begin
            lamport_now = m.stamp;
        end
        if (lamport_now != TIME_MAX) begin
            lamport_now = lamport_now + TIME_BITS'(1);
        end
        case (m.action)
            ACT_INSERT: begin
                n_inserts++;
                if (held_count == QUEUE_DEPTH) begin
                    r.dropped = 1'b1;
                    n_dropped++;
                end else begin
                    fresh = '{time_stamp: m.stamp, source: m.source, role: m.role};
                    // Slide later keys up; an equal key stays ahead of the new entry.
                    pos = held_count;
                    while (pos > 0 && (held[pos - 1].time_stamp > fresh.time_stamp ||
                           (held[pos - 1].time_stamp == fresh.time_stamp &&
                            held[pos - 1].source > fresh.source))) begin
                        held[pos] = held[pos - 1];
                        pos--;
                    end
                    held[pos] = fresh;
                    held_count++;
                end
            end
            ACT_REMOVE: begin
                n_removes++;
                drop_first_of_role(ROLE_VICTIM);
                drop_first_of_role(ROLE_KILLER);
            end
            default: begin
                n_queries++;
            end
        endcase
        for (int k = 0; k < held_count; k++) begin
            if (!r.killer_seen && held[k].role == ROLE_KILLER) begin
                r.killer_seen = 1'b1;
                r.killer_src  = held[k].source;
            end
        end
        r.depth   = CNT_BITS'(held_count);
        r.lamport = lamport_now;
        if (held_count > peak_depth) begin
            peak_depth = held_count;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        $display("[%0t] result %0d: %s is %0d, expected %0d",
                 $realtime, results_seen, what, got, want);
    endtask

    // Offer one item after a random gap, hold it until taken, then log its result.
    task automatic send_message(input t_message m, input logic pinned, input t_report want);
        t_report predicted;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {m.source, m.stamp};
        s_tuser  <= {m.role, m.action};
        do @(posedge clk); while (!s_tready);
        predicted = apply_message(m);
        pending_reports.push_back(pinned ? want : predicted);
    endtask

    // Drop valid and hold off until every logged result has come back.
    task automatic wait_for_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Alternate fill and drain runs so the queue keeps hitting empty and full;
    // bias timestamps near the clock so it climbs slowly instead of saturating.
    task automatic send_random_stream(input int count);
        t_message m;
        int       pick;
        int       ahead;
        for (int n = 0; n < count; n++) begin
            if (held_count == 0) begin
                filling = 1'b1;
            end else if (held_count == QUEUE_DEPTH && $urandom_range(0, 2) != 0) begin
                filling = 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
                filling = !filling;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                m.action = ACT_SPARE;
            end else if (pick < 10) begin
                m.action = ACT_QUERY;
            end else if ((pick < 78) == filling) begin
                m.action = ACT_INSERT;
            end else begin
                m.action = ACT_REMOVE;
            end
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                m.stamp = last_stamp;
            end else if (pick < 50) begin
                ahead   = int'(lamport_now) + int'($urandom_range(0, 40));
                m.stamp = (ahead > 60000) ? TIME_BITS'(60000) : TIME_BITS'(ahead);
            end else begin
                m.stamp = TIME_BITS'($urandom_range(0, int'(lamport_now)));
            end
            // Crowd half the sources into a few values to force key ties.
            if ($urandom_range(0, 1) != 0) begin
                m.source = SOURCE_BITS'($urandom_range(0, 3));
            end else begin
                m.source = SOURCE_BITS'($urandom());
            end
            m.role = 1'($urandom_range(0, 1));
            if (m.action == ACT_INSERT) begin
                last_stamp = m.stamp;
            end
            send_message(m, 1'b0, NO_PIN);
        end
    endtask

    // Stall the result side at random, on the falling edge.
    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Compare every taken result with the oldest logged one, field by field.
    always @(posedge clk) begin
        t_report got;
        t_report want;
        if (rst_n && m_tvalid && m_tready) begin
            got = t_report'(m_tdata[OUT_DATA_BITS-1:0]);
            results_seen++;
            if (pending_reports.size() == 0) begin
                flag_mismatch("result with nothing pending, data", 32'(m_tdata), 32'(0));
            end else begin
                want = pending_reports.pop_front();
                if (got.lamport !== want.lamport) begin
                    flag_mismatch("clock_value", 32'(got.lamport), 32'(want.lamport));
                end
                if (got.depth !== want.depth) begin
                    flag_mismatch("entry_count", 32'(got.depth), 32'(want.depth));
                end
                if (got.killer_seen !== want.killer_seen) begin
                    flag_mismatch("killer_found", 32'(got.killer_seen),
                                  32'(want.killer_seen));
                end
                if (got.killer_src !== want.killer_src) begin
                    flag_mismatch("first_killer_source", 32'(got.killer_src),
                                  32'(want.killer_src));
                end
                if (got.dropped !== want.dropped) begin
                    flag_mismatch("insert_dropped", 32'(got.dropped), 32'(want.dropped));
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_idle_pct    = 30;
        receiver_stall_pct = 70;
        for (int r = 0; r < HOLD_BACK_FROM; r++) begin
            send_message(PLAN[r].msg, PLAN[r].pinned, PLAN[r].want);
        end

        // Three idling patterns; drain fully before each so the sender sits idle
        // while the result side catches up.
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct    = (phase == 0) ? 30 : (phase == 1) ? 70 : 0;
            receiver_stall_pct = (phase == 0) ? 70 : (phase == 1) ? 30 : 0;
            wait_for_drain();
            send_random_stream(ITEMS_PER_PHASE);
        end

        for (int r = HOLD_BACK_FROM; r < PLAN_ROWS; r++) begin
            send_message(PLAN[r].msg, PLAN[r].pinned, PLAN[r].want);
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d messages: %0d inserts (%0d dropped on a full queue), %0d removes,",
                 n_inserts + n_removes + n_queries, n_inserts, n_dropped, n_removes);
        $display("%0d queries; checked %0d results, queue peaked at %0d, clock ended at %0d",
                 n_queries, results_seen, peak_depth, lamport_now);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #LIMIT_NS;
        $display("Timed out with %0d results outstanding", pending_reports.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/lorq_pkg.sv
hdl/lorq_cell.sv
hdl/lorq_lamport_clock.sv
hdl/lamport_ordered_role_queue.sv
test/tb_top.sv
